// ===== rtl/esp_pkg.sv =====
// Shared types and constants of the encoder speed estimator.
package esp_pkg;

  typedef struct packed {
    logic signed [31:0] raw_count;
    logic        [47:0] time_us;
  } esp_in_t;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic signed [31:0] speed_rps_q16;
    logic signed [47:0] accel_rps2_q16;
    logic        [31:0] jump_total;
    logic               rejected;
  } esp_out_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    CFG_CPR     = 3'd0,
    CFG_ABS     = 3'd1,
    CFG_REV     = 3'd2,
    CFG_SPD_LIM = 3'd3,
    CFG_CYC_TO  = 3'd4,
    CFG_VEL_TO  = 3'd5
  } esp_cfg_e;

  localparam logic [15:0] CPR_RST      = 16'd2048;
  localparam logic [31:0] SPD_LIM_RST  = 32'd34314650;
  localparam logic [31:0] CYC_TO_RST   = 32'd100000;
  localparam logic [31:0] VEL_TO_RST   = 32'd100000;

  // 2*pi in Q3.29
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [19:0] US_PER_S     = 20'd1000000;

  localparam int unsigned MulW    = 128;
  localparam int unsigned MulOpW  = 64;
  localparam int unsigned DivNumW = 68;
  localparam int unsigned DivDenW = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_PREP,
    S_MUL_L,
    S_WAIT_L,
    S_MUL_R,
    S_WAIT_R,
    S_DECIDE,
    S_DIV_S,
    S_WAIT_S,
    S_ACC_PREP,
    S_DIV_A,
    S_WAIT_A,
    S_FINAL,
    S_EMIT
  } esp_state_e;

  typedef enum logic {
    MUL_LHS,
    MUL_RHS
  } esp_mul_sel_e;

  typedef enum logic {
    DIV_SPEED,
    DIV_ACCEL
  } esp_div_sel_e;

  typedef struct packed {
    logic         load_in;
    logic         calc_gap;
    logic         prep;
    logic         mul_start;
    esp_mul_sel_e mul_sel;
    logic         save_lhs;
    logic         commit_rej;
    logic         commit_ok;
    logic         div_start;
    esp_div_sel_e div_sel;
    logic         save_speed;
    logic         acc_prep;
    logic         save_accel;
    logic         finalize;
    logic         out_load;
  } esp_cmd_t;

  typedef struct packed {
    logic dt_pos;
    logic gap_nz;
    logic check_limit;
    logic reject;
    logic mul_busy;
    logic div_busy;
  } esp_sts_t;

endpackage

// ===== rtl/encoder_speed_estimator.sv =====
// Encoder speed estimator top level: sequencer plus datapath.
// One request (raw count and microsecond timestamp) is handled at a time and yields one
// result. A request whose time has not advanced past the last count change goes straight
// to the output; a rejected request or an accepted unchanged count skips the divisions.
// The limit test (relative mode, nonzero delta) runs two products on a shift-add
// multiplier, one bit a cycle. A nonzero accepted delta then runs two 68-step restoring
// divisions for speed and acceleration, one after the other. The next request is taken
// while the previous result still waits in the output register.
module encoder_speed_estimator import esp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  esp_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output esp_out_t            out_data_o
);

  esp_cmd_t cmd;
  esp_sts_t sts;

  esp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/esp_mul.sv =====
// Shift-and-add multiplier, one multiplier bit a cycle, stops early when the rest is zero.
module esp_mul import esp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MulOpW-1:0] a_i,
  input  logic [MulOpW-1:0] b_i,
  output logic              busy_o,
  output logic [MulW-1:0]   prod_o
);

  logic              busy_q;
  logic [MulW-1:0]   a_q;
  logic [MulOpW-1:0] b_q;
  logic [MulW-1:0]   prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= {{(MulW-MulOpW){1'b0}}, a_i};
      b_q    <= b_i;
      prod_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        prod_q <= prod_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/esp_div.sv =====
// Restoring divider, one quotient bit a cycle.
module esp_div import esp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               busy_o,
  output logic [DivNumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW:0]   rsh_w;
  logic [DivDenW:0]   rsub_w;
  logic               ge_w;

  assign rsh_w  = {rem_q, num_q[DivNumW-1]};
  assign ge_w   = rsh_w >= {1'b0, den_q};
  assign rsub_w = rsh_w - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DivNumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge_w ? rsub_w[DivDenW-1:0] : rsh_w[DivDenW-1:0];
      num_q <= {num_q[DivNumW-2:0], ge_w};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;

endmodule

// ===== rtl/esp_dp.sv =====
// Datapath: configuration, estimator state, delta handling and the shared mul/div units.
module esp_dp import esp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  esp_in_t             in_data_i,
  input  esp_cmd_t            cmd_i,
  output esp_sts_t            sts_o,
  output esp_out_t            out_data_o
);

  // configuration
  logic [15:0] cpr_q;
  logic        abs_q;
  logic        rev_q;
  logic [31:0] spl_q;
  logic [31:0] cto_q;
  logic [31:0] vto_q;

  // estimator state
  logic        [31:0] prev_q;
  logic        [47:0] lst_q;
  logic        [47:0] lct_q;
  logic        [31:0] acc_q;
  logic signed [31:0] speed_q;
  logic signed [47:0] accel_q;
  logic        [31:0] jumps_q;

  // per-request working registers
  logic        [31:0] raw_q;
  logic        [47:0] t_q;
  logic signed [48:0] dt_q;
  logic signed [33:0] gap_q;
  logic        [31:0] mag_q;
  logic        [51:0] m1_q;
  logic        [47:0] m2_q;
  logic        [63:0] den_q;
  logic               late_q;
  logic [MulW-1:0]    lhs_q;
  logic signed [31:0] ns_q;
  logic        [51:0] anum_q;
  logic               dneg_q;
  logic               rej_q;
  esp_out_t           out_q;

  logic        [15:0] cpr_eff_w;
  logic signed [48:0] dt_w;
  logic signed [48:0] since_w;
  logic        [31:0] d32_w;
  logic signed [33:0] gap0_w;
  logic signed [33:0] cpr34_w;
  logic signed [34:0] two_gap_w;
  logic signed [34:0] cpr35_w;
  logic signed [33:0] gapa_w;
  logic signed [33:0] gapd_w;
  logic signed [33:0] gneg_w;
  logic        [31:0] mag_w;
  logic signed [32:0] diff_w;
  logic signed [32:0] dabs_w;
  logic        [52:0] anum_w;
  logic        [31:0] ns_w;
  logic        [47:0] aq_w;
  logic               gap_nz_w;

  logic [MulOpW-1:0]  mul_a_w;
  logic [MulOpW-1:0]  mul_b_w;
  logic               mul_busy_w;
  logic [MulW-1:0]    prod_w;
  logic [DivNumW-1:0] div_num_w;
  logic [DivDenW-1:0] div_den_w;
  logic               div_busy_w;
  logic [DivNumW-1:0] quot_w;

  assign cpr_eff_w = (cpr_q == '0) ? 16'd1 : cpr_q;
  assign dt_w      = $signed({1'b0, in_data_i.time_us}) - $signed({1'b0, lct_q});
  assign since_w   = $signed({1'b0, t_q}) - $signed({1'b0, lst_q});

  // count delta, wrapped to half a revolution in absolute mode and negated in reverse mode
  always_comb begin
    d32_w     = raw_q - prev_q;
    gap0_w    = $signed({{2{d32_w[31]}}, d32_w});
    cpr34_w   = $signed({18'b0, cpr_eff_w});
    two_gap_w = $signed({gap0_w, 1'b0});
    cpr35_w   = $signed({19'b0, cpr_eff_w});
    if (abs_q && (two_gap_w > cpr35_w)) begin
      gapa_w = gap0_w - cpr34_w;
    end else if (abs_q && (two_gap_w < -cpr35_w)) begin
      gapa_w = gap0_w + cpr34_w;
    end else begin
      gapa_w = gap0_w;
    end
    gapd_w = rev_q ? -gapa_w : gapa_w;
    gneg_w = -gapd_w;
    mag_w  = gapd_w[33] ? gneg_w[31:0] : gapd_w[31:0];
  end

  assign gap_nz_w = gap_q != '0;

  // speed difference scaled for the acceleration division
  always_comb begin
    diff_w = $signed({ns_q[31], ns_q}) - $signed({speed_q[31], speed_q});
    dabs_w = diff_w[32] ? -diff_w : diff_w;
    anum_w = dabs_w * US_PER_S;
  end

  // saturation of the divider results to the output ranges
  always_comb begin
    if (gap_q[33]) begin
      ns_w = (quot_w > 68'h8000_0000) ? 32'h8000_0000 : (32'd0 - quot_w[31:0]);
    end else begin
      ns_w = (quot_w > 68'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot_w[31:0];
    end
    if (dneg_q) begin
      aq_w = (quot_w > 68'h8000_0000_0000) ? 48'h8000_0000_0000
                                           : (48'd0 - quot_w[47:0]);
    end else begin
      aq_w = (quot_w > 68'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : quot_w[47:0];
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LHS: begin
        mul_a_w = {12'b0, m1_q};
        mul_b_w = {32'b0, TWO_PI_Q29};
      end
      MUL_RHS: begin
        mul_a_w = {3'b0, dt_q[47:0], 13'b0};
        mul_b_w = {16'b0, m2_q};
      end
      default: begin
        mul_a_w = '0;
        mul_b_w = '0;
      end
    endcase
    case (cmd_i.div_sel)
      DIV_SPEED: begin
        div_num_w = {m1_q, 16'b0};
        div_den_w = den_q;
      end
      DIV_ACCEL: begin
        div_num_w = {16'b0, anum_q};
        div_den_w = {15'b0, dt_q};
      end
      default: begin
        div_num_w = '0;
        div_den_w = '0;
      end
    endcase
  end

  esp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a_w),
    .b_i     (mul_b_w),
    .busy_o  (mul_busy_w),
    .prod_o  (prod_w)
  );

  esp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num_w),
    .den_i   (div_den_w),
    .busy_o  (div_busy_w),
    .quot_o  (quot_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CPR_RST;
      abs_q <= 1'b0;
      rev_q <= 1'b0;
      spl_q <= SPD_LIM_RST;
      cto_q <= CYC_TO_RST;
      vto_q <= VEL_TO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CPR:     cpr_q <= cfg_data_i[15:0];
        CFG_ABS:     abs_q <= cfg_data_i[0];
        CFG_REV:     rev_q <= cfg_data_i[0];
        CFG_SPD_LIM: spl_q <= cfg_data_i;
        CFG_CYC_TO:  cto_q <= cfg_data_i;
        CFG_VEL_TO:  vto_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      lst_q   <= '0;
      lct_q   <= '0;
      acc_q   <= '0;
      speed_q <= '0;
      accel_q <= '0;
      jumps_q <= '0;
    end else begin
      if (cmd_i.commit_rej) begin
        prev_q  <= raw_q;
        lst_q   <= t_q;
        lct_q   <= t_q;
        jumps_q <= jumps_q + 1'b1;
      end
      if (cmd_i.commit_ok) begin
        prev_q <= raw_q;
        lst_q  <= t_q;
        acc_q  <= acc_q + gap_q[31:0];
      end
      if (cmd_i.save_accel) begin
        accel_q <= aq_w;
        speed_q <= ns_q;
      end
      if (cmd_i.finalize) begin
        if (dt_q > $signed({17'b0, vto_q})) begin
          lct_q   <= t_q;
          accel_q <= -{{16{speed_q[31]}}, speed_q};
          speed_q <= '0;
        end
        if (gap_nz_w) begin
          lct_q <= t_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      raw_q <= in_data_i.raw_count;
      t_q   <= in_data_i.time_us;
      dt_q  <= dt_w;
      rej_q <= 1'b0;
    end
    if (cmd_i.calc_gap) begin
      gap_q <= gapd_w;
      mag_q <= mag_w;
    end
    if (cmd_i.prep) begin
      m1_q   <= mag_q * US_PER_S;
      m2_q   <= spl_q * cpr_eff_w;
      den_q  <= cpr_eff_w * dt_q[47:0];
      late_q <= since_w > $signed({17'b0, cto_q});
    end
    if (cmd_i.save_lhs) begin
      lhs_q <= prod_w;
    end
    if (cmd_i.commit_rej) begin
      rej_q <= 1'b1;
    end
    if (cmd_i.save_speed) begin
      ns_q <= ns_w;
    end
    if (cmd_i.acc_prep) begin
      anum_q <= anum_w[51:0];
      dneg_q <= diff_w[32];
    end
    if (cmd_i.out_load) begin
      out_q.position_count <= acc_q;
      out_q.speed_rps_q16  <= speed_q;
      out_q.accel_rps2_q16 <= accel_q;
      out_q.jump_total     <= jumps_q;
      out_q.rejected       <= rej_q;
    end
  end

  always_comb begin
    sts_o.dt_pos      = dt_q > 49'sd0;
    sts_o.gap_nz      = gap_nz_w;
    sts_o.check_limit = gap_nz_w && !abs_q;
    sts_o.reject      = late_q || (gap_nz_w && !abs_q && (lhs_q > prod_w));
    sts_o.mul_busy    = mul_busy_w;
    sts_o.div_busy    = div_busy_w;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/esp_ctrl.sv =====
// Sequencer: walks one request through gap, limit test, speed and acceleration.
module esp_ctrl import esp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  esp_sts_t sts_i,
  output esp_cmd_t cmd_o
);

  esp_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DELTA;
        end
      end
      S_DELTA: begin
        if (sts_i.dt_pos) begin
          cmd_o.calc_gap = 1'b1;
          state_d        = S_PREP;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.check_limit ? S_MUL_L : S_DECIDE;
      end
      S_MUL_L: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_LHS;
        state_d         = S_WAIT_L;
      end
      S_WAIT_L: begin
        if (!sts_i.mul_busy) begin
          cmd_o.save_lhs = 1'b1;
          state_d        = S_MUL_R;
        end
      end
      S_MUL_R: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_RHS;
        state_d         = S_WAIT_R;
      end
      S_WAIT_R: begin
        if (!sts_i.mul_busy) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.reject) begin
          cmd_o.commit_rej = 1'b1;
          state_d          = S_EMIT;
        end else begin
          cmd_o.commit_ok = 1'b1;
          state_d         = sts_i.gap_nz ? S_DIV_S : S_FINAL;
        end
      end
      S_DIV_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SPEED;
        state_d         = S_WAIT_S;
      end
      S_WAIT_S: begin
        if (!sts_i.div_busy) begin
          cmd_o.save_speed = 1'b1;
          state_d          = S_ACC_PREP;
        end
      end
      S_ACC_PREP: begin
        cmd_o.acc_prep = 1'b1;
        state_d        = S_DIV_A;
      end
      S_DIV_A: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ACCEL;
        state_d         = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (!sts_i.div_busy) begin
          cmd_o.save_accel = 1'b1;
          state_d          = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.finalize = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        // result register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |-> !sts_i.mul_busy)
    else $error("multiplier restarted while busy");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_accept_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (!sts_i.mul_busy && !sts_i.div_busy))
    else $error("request accepted while an arithmetic unit is busy");

  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.commit_rej && cmd_o.commit_ok))
    else $error("request both rejected and accepted");
`endif

endmodule
